### rtl/bbd_pkg.sv
`timescale 1ns / 1ps

package bbd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 13;
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // register index taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // per-request position info carried from acceptance to the result stage
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             row_ge1;
        logic             col_ge1;
        logic             last_col;
        logic             last_row;
        logic             left_mirror;
        logic             top_mirror;
    } item_info_t;

    // last usable index of a dimension, size clamped to 2..maxv
    function automatic logic [COL_W-1:0] clamp_last(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] t;
        begin
            if (v < DIM_W'(2))
            begin
                t = DIM_W'(1);
            end
            else if (v > maxv)
            begin
                t = maxv - DIM_W'(1);
            end
            else
            begin
                t = v - DIM_W'(1);
            end
            return t[COL_W-1:0];
        end
    endfunction

endpackage

### rtl/bayer_bilinear_demosaic.sv
`timescale 1ns / 1ps
// path: an accepted request passes through the read stage, then the result stage, then the output register
// throughput: one request per cycle while each causes at most one result and the output is not
//   stalled; a request at the last column or last row can cause up to four results, which the
//   result sequencer hands to the output register one at a time while holding the single result stage
// reset: position counters clear, frame size returns to 640 x 480, pipeline empties;
//   the two line memories are not cleared and are always written before use
module bayer_bilinear_demosaic
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bbd_pkg::ADDR_W-1:0]     paddr,
    input  logic [bbd_pkg::DATA_W-1:0]     pwdata,
    output logic [bbd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bbd_pkg::PIX_W-1:0]      raw_pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bbd_pkg::PIX_W-1:0]      red,
    output logic [bbd_pkg::PIX_W-1:0]      green,
    output logic [bbd_pkg::PIX_W-1:0]      blue,
    output logic [bbd_pkg::ROW_W-1:0]      out_row,
    output logic [bbd_pkg::COL_W-1:0]      out_col,
    output logic                           last_of_run,
    output logic                           end_of_frame
);

    localparam int PW = bbd_pkg::PIX_W;

    // configuration
    logic [bbd_pkg::DIM_W-1:0] frame_width_reg;
    logic [bbd_pkg::DIM_W-1:0] frame_height_reg;
    logic [bbd_pkg::COL_W-1:0] width_last_reg;
    logic [bbd_pkg::ROW_W-1:0] height_last_reg;
    logic                      cfg_write;

    // input position
    logic [bbd_pkg::COL_W-1:0] in_col_reg;
    logic [bbd_pkg::COL_W-1:0] in_col_next;
    logic [bbd_pkg::ROW_W-1:0] in_row_reg;
    logic [bbd_pkg::ROW_W-1:0] in_row_next;
    logic                      in_accept;
    bbd_pkg::item_info_t       in_info;

    // line memories
    logic [PW-1:0] older_mem [bbd_pkg::MAX_WIDTH];
    logic [PW-1:0] newer_mem [bbd_pkg::MAX_WIDTH];
    logic [PW-1:0] rd_older_reg;
    logic [PW-1:0] rd_newer_reg;

    // read stage
    logic                s1_valid_reg;
    bbd_pkg::item_info_t s1_info_reg;
    logic [PW-1:0]       s1_pixel_reg;
    logic                s1_go;

    // result stage
    logic [PW-1:0]       win_reg [3][3];
    logic [3:0]          job_pend_reg;
    logic [3:0]          job_pend_next;
    bbd_pkg::item_info_t job_info_reg;
    logic [3:0]          new_mask;
    logic [3:0]          sel;
    logic                job_last;
    logic                out_load;
    logic                use_last_col;
    logic                bottom;

    logic [PW-1:0] lv [3];
    logic [PW-1:0] cv [3];
    logic [PW-1:0] rv [3];
    logic [PW-1:0] tl, tc, tr, ml, mc, mr, bl, bc, br;
    logic [PW+1:0] cross_sum;
    logic [PW+1:0] diag_sum;
    logic [PW:0]   horiz_sum;
    logic [PW:0]   vert_sum;
    logic [PW-1:0] red_next, green_next, blue_next;
    logic [bbd_pkg::ROW_W-1:0] prow;
    logic [bbd_pkg::COL_W-1:0] pcol;

    // output register
    logic                      out_valid_reg;
    logic [PW-1:0]             red_reg, green_reg, blue_reg;
    logic [bbd_pkg::ROW_W-1:0] out_row_reg;
    logic [bbd_pkg::COL_W-1:0] out_col_reg;
    logic                      last_of_run_reg;
    logic                      end_of_frame_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            bbd_pkg::REG_FRAME_WIDTH:
            begin
                prdata = bbd_pkg::DATA_W'(frame_width_reg);
            end
            bbd_pkg::REG_FRAME_HEIGHT:
            begin
                prdata = bbd_pkg::DATA_W'(frame_height_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bbd_pkg::WIDTH_RESET;
            frame_height_reg <= bbd_pkg::HEIGHT_RESET;
            width_last_reg   <= bbd_pkg::COL_W'(bbd_pkg::WIDTH_RESET - 13'd1);
            height_last_reg  <= bbd_pkg::ROW_W'(bbd_pkg::HEIGHT_RESET - 13'd1);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == bbd_pkg::REG_FRAME_WIDTH)
            begin
                frame_width_reg <= pwdata[bbd_pkg::DIM_W-1:0];
                width_last_reg  <= bbd_pkg::clamp_last(pwdata[bbd_pkg::DIM_W-1:0],
                                       bbd_pkg::DIM_W'(bbd_pkg::MAX_WIDTH));
            end
            else
            begin
                frame_height_reg <= pwdata[bbd_pkg::DIM_W-1:0];
                height_last_reg  <= bbd_pkg::ROW_W'(bbd_pkg::clamp_last(
                                        pwdata[bbd_pkg::DIM_W-1:0],
                                        bbd_pkg::DIM_W'(bbd_pkg::MAX_HEIGHT)));
            end
        end
    end

    // ---------------- input position ----------------
    assign in_ready  = !s1_valid_reg || s1_go;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        in_info.col         = in_col_reg;
        in_info.row         = in_row_reg;
        in_info.row_ge1     = (in_row_reg != '0);
        in_info.col_ge1     = (in_col_reg != '0);
        in_info.last_col    = (in_col_reg == width_last_reg);
        in_info.last_row    = (in_row_reg == height_last_reg);
        in_info.left_mirror = (in_col_reg == bbd_pkg::COL_W'(1));
        in_info.top_mirror  = (in_row_reg == bbd_pkg::ROW_W'(1));

        in_col_next = in_col_reg + bbd_pkg::COL_W'(1);
        in_row_next = in_row_reg;
        if (in_info.last_col)
        begin
            in_col_next = '0;
            in_row_next = in_info.last_row ? '0 : in_row_reg + bbd_pkg::ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (cfg_write)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (in_accept)
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    // ---------------- line memories ----------------
    // read on acceptance, write back when the request leaves the read stage;
    // neighboring requests differ in column, so the two do not collide unless a size write intervenes
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_older_reg <= older_mem[in_col_reg];
            rd_newer_reg <= newer_mem[in_col_reg];
        end
        if (s1_go)
        begin
            older_mem[s1_info_reg.col] <= rd_newer_reg;
            newer_mem[s1_info_reg.col] <= s1_pixel_reg;
        end
    end

    // ---------------- read stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_info_reg  <= in_info;
            s1_pixel_reg <= raw_pixel;
        end
    end

    // ---------------- result stage ----------------
    always_comb
    begin
        if (s1_info_reg.row_ge1)
        begin
            new_mask = {s1_info_reg.last_row && s1_info_reg.last_col,
                        s1_info_reg.last_row && s1_info_reg.col_ge1,
                        s1_info_reg.last_col,
                        s1_info_reg.col_ge1};
        end
        else
        begin
            new_mask = '0;
        end
    end

    // lowest pending result goes first
    assign sel      = job_pend_reg & (~job_pend_reg + 4'd1);
    assign job_last = ((job_pend_reg & ~sel) == 4'd0);
    assign out_load = (job_pend_reg != 4'd0) && (!out_valid_reg || out_ready);
    assign s1_go    = s1_valid_reg && ((job_pend_reg == 4'd0) || (out_load && job_last));

    always_comb
    begin
        if (s1_go)
        begin
            job_pend_next = new_mask;
        end
        else if (out_load)
        begin
            job_pend_next = job_pend_reg & ~sel;
        end
        else
        begin
            job_pend_next = job_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_pend_reg <= '0;
        end
        else
        begin
            job_pend_reg <= job_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            job_info_reg <= s1_info_reg;
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd_older_reg;
            win_reg[1][2] <= rd_newer_reg;
            win_reg[2][2] <= s1_pixel_reg;
        end
    end

    // window taps with mirror padding at the edges
    assign use_last_col = sel[1] || sel[3];
    assign bottom       = sel[2] || sel[3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (use_last_col)
            begin
                lv[r] = win_reg[r][1];
                cv[r] = win_reg[r][2];
                rv[r] = win_reg[r][1];
            end
            else
            begin
                lv[r] = job_info_reg.left_mirror ? win_reg[r][2] : win_reg[r][0];
                cv[r] = win_reg[r][1];
                rv[r] = win_reg[r][2];
            end
        end

        if (bottom)
        begin
            tl = lv[1]; tc = cv[1]; tr = rv[1];
            ml = lv[2]; mc = cv[2]; mr = rv[2];
            bl = lv[1]; bc = cv[1]; br = rv[1];
        end
        else
        begin
            tl = job_info_reg.top_mirror ? lv[2] : lv[0];
            tc = job_info_reg.top_mirror ? cv[2] : cv[0];
            tr = job_info_reg.top_mirror ? rv[2] : rv[0];
            ml = lv[1]; mc = cv[1]; mr = rv[1];
            bl = lv[2]; bc = cv[2]; br = rv[2];
        end

        prow = bottom ? job_info_reg.row : job_info_reg.row - bbd_pkg::ROW_W'(1);
        pcol = use_last_col ? width_last_reg : job_info_reg.col - bbd_pkg::COL_W'(1);

        cross_sum = (PW+2)'(ml) + (PW+2)'(mr) + (PW+2)'(tc) + (PW+2)'(bc);
        diag_sum  = (PW+2)'(tl) + (PW+2)'(tr) + (PW+2)'(bl) + (PW+2)'(br);
        horiz_sum = (PW+1)'(ml) + (PW+1)'(mr);
        vert_sum  = (PW+1)'(tc) + (PW+1)'(bc);

        unique case ({prow[0], pcol[0]})
            2'b11:
            begin
                red_next   = mc;
                green_next = cross_sum[PW+1:2];
                blue_next  = diag_sum[PW+1:2];
            end
            2'b10:
            begin
                red_next   = horiz_sum[PW:1];
                green_next = mc;
                blue_next  = vert_sum[PW:1];
            end
            2'b01:
            begin
                red_next   = vert_sum[PW:1];
                green_next = mc;
                blue_next  = horiz_sum[PW:1];
            end
            default:
            begin
                red_next   = diag_sum[PW+1:2];
                green_next = cross_sum[PW+1:2];
                blue_next  = mc;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg          <= red_next;
            green_reg        <= green_next;
            blue_reg         <= blue_next;
            out_row_reg      <= prow;
            out_col_reg      <= pcol;
            last_of_run_reg  <= job_last;
            end_of_frame_reg <= sel[3];
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign last_of_run  = last_of_run_reg;
    assign end_of_frame = end_of_frame_reg;

    // ---------------- assertions ----------------
    a_no_mem_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s1_go) |-> (in_col_reg != s1_info_reg.col))
        else $error("line memory read and write hit the same column");

    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> last_of_run)
        else $error("end of frame result is not the last of its run");

    a_eof_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> (out_col == width_last_reg && out_row == height_last_reg))
        else $error("end of frame flagged away from the bottom-right pixel");

    a_job_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |=> (job_pend_reg == $past(new_mask)))
        else $error("result stage took a request while results were pending");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT  = 300000;
    localparam int SETTLE = 8;
    localparam int RANDOM_ITEMS = 145;

    localparam logic [bbd_pkg::ADDR_W-1:0] ADDR_WIDTH  = {bbd_pkg::REG_FRAME_WIDTH, 2'b00};
    localparam logic [bbd_pkg::ADDR_W-1:0] ADDR_HEIGHT = {bbd_pkg::REG_FRAME_HEIGHT, 2'b00};

    typedef struct packed {
        logic [bbd_pkg::PIX_W-1:0] r;
        logic [bbd_pkg::PIX_W-1:0] g;
        logic [bbd_pkg::PIX_W-1:0] b;
        logic [bbd_pkg::ROW_W-1:0] row;
        logic [bbd_pkg::COL_W-1:0] col;
        logic                      lor;
        logic                      eof;
    } rgb_pixel_t;

    // one directed request; a new frame size is written first when resize is set
    typedef struct packed {
        logic                      resize;
        logic [bbd_pkg::DIM_W-1:0] w;
        logic [bbd_pkg::DIM_W-1:0] h;
        logic [bbd_pkg::PIX_W-1:0] pix;
        logic                      known;
        logic [bbd_pkg::PIX_W-1:0] colour;
    } plan_row_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [bbd_pkg::ADDR_W-1:0]    paddr     = '0;
    logic [bbd_pkg::DATA_W-1:0]    pwdata    = '0;
    logic [bbd_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic [bbd_pkg::PIX_W-1:0]     raw_pixel = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [bbd_pkg::PIX_W-1:0]     red;
    logic [bbd_pkg::PIX_W-1:0]     green;
    logic [bbd_pkg::PIX_W-1:0]     blue;
    logic [bbd_pkg::ROW_W-1:0]     out_row;
    logic [bbd_pkg::COL_W-1:0]     out_col;
    logic                          last_of_run;
    logic                          end_of_frame;

    // predictor state
    logic [bbd_pkg::DIM_W-1:0]     width_reg;
    logic [bbd_pkg::DIM_W-1:0]     height_reg;
    logic [bbd_pkg::PIX_W-1:0]     older_mem [bbd_pkg::MAX_WIDTH];
    logic [bbd_pkg::PIX_W-1:0]     newer_mem [bbd_pkg::MAX_WIDTH];
    logic [bbd_pkg::PIX_W-1:0]     win [3][3];
    int unsigned                   col_pos;
    int unsigned                   row_pos;

    rgb_pixel_t                    pending_pixels [$];

    int unsigned                   errors;
    int unsigned                   pixels_sent;
    int unsigned                   results_checked;
    int unsigned                   frame_settings;
    int unsigned                   burst_left;
    int unsigned                   cycle_count;
    int unsigned                   rx_count;
    rx_mode_t                      rx_mode;

    plan_row_t                     plan [22];

    bayer_bilinear_demosaic DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_pixel    (raw_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     pending_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stall pattern, switching at random among four styles
    always @(posedge clk)
    begin
        rx_count++;
        if (rx_count % 48 == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_FREE:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= ((rx_count % 9) < 5);
        endcase
    end

    function automatic logic [bbd_pkg::DIM_W-1:0] dim_used(
        input logic [bbd_pkg::DIM_W-1:0] v,
        input int unsigned maxv);
        if (v < 2)
        begin
            return bbd_pkg::DIM_W'(2);
        end
        if (v > maxv)
        begin
            return bbd_pkg::DIM_W'(maxv);
        end
        return v;
    endfunction

    // bilinear colour of one pixel from the selected window taps
    function automatic rgb_pixel_t demosaic_at(input int unsigned prow, input int unsigned pcol,
                                               input int cl, input int cc, input int cr,
                                               input int rt, input int rm, input int rb);
        rgb_pixel_t  px;
        int unsigned cross_avg;
        int unsigned diag_avg;
        int unsigned horiz_avg;
        int unsigned vert_avg;
        cross_avg = (win[rm][cl] + win[rm][cr] + win[rt][cc] + win[rb][cc]) / 4;
        diag_avg  = (win[rt][cl] + win[rt][cr] + win[rb][cl] + win[rb][cr]) / 4;
        horiz_avg = (win[rm][cl] + win[rm][cr]) / 2;
        vert_avg  = (win[rt][cc] + win[rb][cc]) / 2;
        px = '0;
        px.row = prow[bbd_pkg::ROW_W-1:0];
        px.col = pcol[bbd_pkg::COL_W-1:0];
        if (prow[0] && pcol[0])
        begin
            px.r = win[rm][cc];
            px.g = cross_avg[bbd_pkg::PIX_W-1:0];
            px.b = diag_avg[bbd_pkg::PIX_W-1:0];
        end
        else if (prow[0])
        begin
            px.r = horiz_avg[bbd_pkg::PIX_W-1:0];
            px.g = win[rm][cc];
            px.b = vert_avg[bbd_pkg::PIX_W-1:0];
        end
        else if (pcol[0])
        begin
            px.r = vert_avg[bbd_pkg::PIX_W-1:0];
            px.g = win[rm][cc];
            px.b = horiz_avg[bbd_pkg::PIX_W-1:0];
        end
        else
        begin
            px.r = diag_avg[bbd_pkg::PIX_W-1:0];
            px.g = cross_avg[bbd_pkg::PIX_W-1:0];
            px.b = win[rm][cc];
        end
        return px;
    endfunction

    // advance line stores and window by one request, queue the pixels it finishes
    task automatic predict_request(input logic [bbd_pkg::PIX_W-1:0] p);
        rgb_pixel_t  res [4];
        int          n;
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int          top;
        int          left;
        bit          last_col;
        bit          last_row;
        logic [bbd_pkg::PIX_W-1:0] above2;
        logic [bbd_pkg::PIX_W-1:0] above1;
        w = dim_used(width_reg, bbd_pkg::MAX_WIDTH);
        h = dim_used(height_reg, bbd_pkg::MAX_HEIGHT);
        x = col_pos;
        y = row_pos;
        n = 0;
        above2 = older_mem[x];
        above1 = newer_mem[x];
        older_mem[x] = above1;
        newer_mem[x] = p;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = above2;
        win[1][2] = above1;
        win[2][2] = p;
        if (y >= 1)
        begin
            top      = (y == 1) ? 2 : 0;
            left     = (x == 1) ? 2 : 0;
            last_col = (x == w - 1);
            last_row = (y == h - 1);
            if (x >= 1)
            begin
                res[n] = demosaic_at(y - 1, x - 1, left, 1, 2, top, 1, 2);
                n++;
            end
            if (last_col)
            begin
                res[n] = demosaic_at(y - 1, w - 1, 1, 2, 1, top, 1, 2);
                n++;
            end
            // bottom row mirrors the row above it
            if (last_row && x >= 1)
            begin
                res[n] = demosaic_at(y, x - 1, left, 1, 2, 1, 2, 1);
                n++;
            end
            if (last_row && last_col)
            begin
                res[n] = demosaic_at(y, w - 1, 1, 2, 1, 1, 2, 1);
                res[n].eof = 1'b1;
                n++;
            end
            if (n > 0)
            begin
                res[n-1].lor = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            pending_pixels.push_back(res[i]);
        end
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h)
            begin
                y = 0;
            end
        end
        col_pos = x;
        row_pos = y;
    endtask

    task automatic check_field(input string what, input logic [11:0] want_v,
                               input logic [11:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rgb_pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual row %0d col %0d",
                         $time, out_row, out_col);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("red", 12'(want.r), 12'(red));
                check_field("green", 12'(want.g), 12'(green));
                check_field("blue", 12'(want.b), 12'(blue));
                check_field("out_row", want.row, out_row);
                check_field("out_col", want.col, out_col);
                check_field("last_of_run", 12'(want.lor), 12'(last_of_run));
                check_field("end_of_frame", 12'(want.eof), 12'(end_of_frame));
                results_checked++;
            end
        end
    end

    task automatic apb_write(input logic [bbd_pkg::ADDR_W-1:0] addr,
                             input logic [bbd_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [bbd_pkg::ADDR_W-1:0] addr,
                                  input logic [bbd_pkg::DATA_W-1:0] want_v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want_v)
        begin
            $display("%0t: register %0d read mismatch, expected %0d actual %0d",
                     $time, addr, want_v, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // any write restarts the frame at pixel (0,0)
    task automatic set_frame(input logic [bbd_pkg::DATA_W-1:0] wdata,
                             input logic [bbd_pkg::DATA_W-1:0] hdata);
        apb_write(ADDR_WIDTH, wdata);
        width_reg = wdata[bbd_pkg::DIM_W-1:0];
        col_pos   = 0;
        row_pos   = 0;
        apb_write(ADDR_HEIGHT, hdata);
        height_reg = hdata[bbd_pkg::DIM_W-1:0];
        apb_read_check(ADDR_WIDTH, bbd_pkg::DATA_W'(width_reg));
        apb_read_check(ADDR_HEIGHT, bbd_pkg::DATA_W'(height_reg));
        frame_settings++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_pixel(input logic [bbd_pkg::PIX_W-1:0] p, input bit known,
                              input logic [bbd_pkg::PIX_W-1:0] colour);
        int unsigned gap;
        int unsigned first_new;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid  <= 1'b1;
        raw_pixel <= p;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        first_new = pending_pixels.size();
        predict_request(p);
        if (known)
        begin
            for (int k = first_new; k < pending_pixels.size(); k++)
            begin
                pending_pixels[k].r = colour;
                pending_pixels[k].g = colour;
                pending_pixels[k].b = colour;
            end
        end
        pixels_sent++;
    endtask

    initial
    begin
        logic [bbd_pkg::DIM_W-1:0] w;
        logic [bbd_pkg::DIM_W-1:0] h;
        int unsigned               frame_len;
        int unsigned               n_items;
        int unsigned               random_sent;
        bit                        paused_once;
        logic [bbd_pkg::PIX_W-1:0] p;

        width_reg   = bbd_pkg::WIDTH_RESET;
        height_reg  = bbd_pkg::HEIGHT_RESET;
        col_pos     = 0;
        row_pos     = 0;
        errors      = 0;
        pixels_sent = 0;
        results_checked = 0;
        frame_settings  = 0;
        burst_left  = 0;
        cycle_count = 0;
        rx_count    = 0;
        rx_mode     = RX_FREE;
        random_sent = 0;
        paused_once = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                win[i][j] = '0;
            end
        end

        // default size first, then 2x2 from under-range values: a flat black frame
        // and a flat white one, then a 3x3 with mixed values, then over-range sizes
        plan = '{
            '{1'b0, 13'd0,    13'd0,    8'd200, 1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd13,  1'b0, 8'd0},
            '{1'b1, 13'd1,    13'd0,    8'd0,   1'b1, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd0,   1'b1, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd0,   1'b1, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd0,   1'b1, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd255, 1'b1, 8'd255},
            '{1'b0, 13'd0,    13'd0,    8'd255, 1'b1, 8'd255},
            '{1'b0, 13'd0,    13'd0,    8'd255, 1'b1, 8'd255},
            '{1'b0, 13'd0,    13'd0,    8'd255, 1'b1, 8'd255},
            '{1'b1, 13'd3,    13'd3,    8'd0,   1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd255, 1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd128, 1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd1,   1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd254, 1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd127, 1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd85,  1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd170, 1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd2,   1'b0, 8'd0},
            '{1'b1, 13'd8191, 13'd8191, 8'd255, 1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd0,   1'b0, 8'd0},
            '{1'b0, 13'd0,    13'd0,    8'd77,  1'b0, 8'd0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_read_check(ADDR_WIDTH, bbd_pkg::DATA_W'(bbd_pkg::WIDTH_RESET));
        apb_read_check(ADDR_HEIGHT, bbd_pkg::DATA_W'(bbd_pkg::HEIGHT_RESET));

        foreach (plan[i])
        begin
            if (plan[i].resize)
            begin
                wait_idle();
                set_frame(bbd_pkg::DATA_W'(plan[i].w), bbd_pkg::DATA_W'(plan[i].h));
            end
            send_pixel(plan[i].pix, plan[i].known, plan[i].colour);
        end

        // random sizes: mostly whole frames, some cut short by a resize, some run for two whole frames
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            w = ($urandom_range(0, 9) == 0) ? bbd_pkg::DIM_W'($urandom_range(0, 1))
                                            : bbd_pkg::DIM_W'($urandom_range(2, 9));
            h = ($urandom_range(0, 9) == 0) ? bbd_pkg::DIM_W'($urandom_range(0, 1))
                                            : bbd_pkg::DIM_W'($urandom_range(2, 5));
            set_frame(($urandom() & 32'hFFFF_E000) | bbd_pkg::DATA_W'(w),
                      ($urandom() & 32'hFFFF_E000) | bbd_pkg::DATA_W'(h));
            frame_len = dim_used(w, bbd_pkg::MAX_WIDTH) * dim_used(h, bbd_pkg::MAX_HEIGHT);
            case ($urandom_range(0, 4))
                0:       n_items = $urandom_range(1, frame_len - 1);
                1:       n_items = 2 * frame_len;
                default: n_items = frame_len;
            endcase
            for (int i = 0; i < n_items; i++)
            begin
                // hold the source until the output side has caught up
                if (i == n_items / 2 && (!paused_once || $urandom_range(0, 3) == 0))
                begin
                    wait_idle();
                    paused_once = 1;
                end
                case ($urandom_range(0, 9))
                    0:       p = '0;
                    1:       p = '1;
                    default: p = bbd_pkg::PIX_W'($urandom_range(0, 255));
                endcase
                send_pixel(p, 1'b0, '0);
            end
            random_sent += n_items;
        end

        wait_idle();
        if (pending_pixels.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_pixels.size());
            errors++;
        end
        $display("run covered %0d raw pixels across %0d frame size settings", pixels_sent,
                 frame_settings);
        $display("%0d rgb results compared, %0d mismatches", results_checked, errors);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
